// File: design/channel_level_meter_peak_hold_macros.svh
// Assertion macros for the channel level meter with peak hold.
`ifndef CHANNEL_LEVEL_METER_PEAK_HOLD_MACROS_SVH
`define CHANNEL_LEVEL_METER_PEAK_HOLD_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define CLM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define CLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CLM_ASSERT_IMP(label, ante, cons, msg)
`define CLM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: design/clm_pkg.sv
// Shared types and constants for the channel level meter with peak hold.
package clm_pkg;

    localparam int CHANNELS  = 16;
    localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W      = 4;
    localparam int VEL_W     = 7;
    localparam int LEVEL_W   = 15;
    localparam int HOLD_W    = 8;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] BAR_FALLOFF_RST  = 15'd1024;
    localparam logic [LEVEL_W-1:0] PEAK_FALLOFF_RST = 15'd256;
    localparam logic [HOLD_W-1:0]  PEAK_HOLD_RST    = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAR_FALLOFF  = 2'd0,
        REG_PEAK_FALLOFF = 2'd1,
        REG_PEAK_HOLD    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] bar;
        logic [LEVEL_W-1:0] peak;
        logic [HOLD_W-1:0]  hold;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [LEVEL_W-1:0] bar_falloff;
        logic [LEVEL_W-1:0] peak_falloff;
        logic [HOLD_W-1:0]  peak_hold_frames;
    } cfg_t;

endpackage

// File: design/clm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module clm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/clm_update.sv
// Per-frame bar and peak update for one channel entry.
module clm_update (
    input  clm_pkg::cfg_t                    cfg,
    input  clm_pkg::entry_t                  cur,
    input  logic [clm_pkg::VEL_W-1:0]        velocity,
    output clm_pkg::entry_t                  upd
);

    logic [clm_pkg::LEVEL_W-1:0] level;
    logic [clm_pkg::LEVEL_W-1:0] bar_new;
    logic [clm_pkg::LEVEL_W-1:0] peak_cap;
    logic [clm_pkg::HOLD_W-1:0]  hold_cap;
    logic                        capture;

    always_comb
    begin
        level = {velocity, {clm_pkg::FRAC_W{1'b0}}};

        // Jump up to the new level, or fall by the falloff floored at zero.
        if (level >= cur.bar)
        begin
            bar_new = level;
        end
        else if (cur.bar > cfg.bar_falloff)
        begin
            bar_new = cur.bar - cfg.bar_falloff;
        end
        else
        begin
            bar_new = '0;
        end

        capture  = (bar_new >= cur.peak);
        peak_cap = capture ? bar_new : cur.peak;
        hold_cap = capture ? cfg.peak_hold_frames : cur.hold;

        upd.bar  = bar_new;
        upd.peak = peak_cap;
        upd.hold = hold_cap;

        // Decay once the hold runs out; otherwise count the hold down.
        if (hold_cap == '0)
        begin
            if (peak_cap > cfg.peak_falloff)
            begin
                upd.peak = peak_cap - cfg.peak_falloff;
            end
            else
            begin
                upd.peak = '0;
            end
        end
        else
        begin
            upd.hold = hold_cap - 1'b1;
        end
    end

endmodule

// File: design/channel_level_meter_peak_hold.sv
// Top level of the per-channel bar meter with peak hold.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  item     | item_valid/item_stall     | channel, velocity
//  result   | result_valid/result_stall | channel_out, bar_level, peak_level
//  config   | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// One item per cycle while the result side is not stalled; each result is registered
// after its beat is taken: the state RAM read and the stage registers load at the
// accept edge, and the update lands in the result register when the stage advances.
// The last RAM write is kept in a bypass register, so back-to-back beats on the same
// channel see fresh state. Per-channel valid flops clear the state at reset, with no
// clearing pass. A stalled result holds the update stage and the item side.
module channel_level_meter_peak_hold (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [clm_pkg::CH_W-1:0]           channel,
    input  logic [clm_pkg::VEL_W-1:0]          velocity,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [clm_pkg::CH_W-1:0]           channel_out,
    output logic [clm_pkg::LEVEL_W-1:0]        bar_level,
    output logic [clm_pkg::LEVEL_W-1:0]        peak_level,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [clm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clm_pkg::LEVEL_W-1:0]        cfg_data
);

    `include "channel_level_meter_peak_hold_macros.svh"

    clm_pkg::cfg_t   cfg_reg;
    clm_pkg::cfg_t   cfg_next;

    logic            accept;
    logic            advance;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [clm_pkg::CH_W-1:0]    s1_ch_reg;
    logic [clm_pkg::VEL_W-1:0]   s1_vel_reg;
    logic                        s1_seen_reg;
    logic                        s1_inrange_reg;

    logic [clm_pkg::CHANNELS-1:0] seen_reg;
    logic [clm_pkg::CHANNELS-1:0] seen_next;

    logic                        fwd_valid_reg;
    logic [clm_pkg::ADDR_W-1:0]  fwd_addr_reg;
    clm_pkg::entry_t             fwd_data_reg;

    logic [clm_pkg::ADDR_W-1:0]  rd_addr;
    logic [clm_pkg::ADDR_W-1:0]  s1_addr;
    logic                        in_range;
    logic [clm_pkg::ENTRY_W-1:0] rd_data;
    clm_pkg::entry_t             cur;
    clm_pkg::entry_t             upd;
    logic                        wr_en;

    logic                        result_valid_reg;
    logic                        result_valid_next;
    logic [clm_pkg::CH_W-1:0]    channel_out_reg;
    logic [clm_pkg::LEVEL_W-1:0] bar_level_reg;
    logic [clm_pkg::LEVEL_W-1:0] peak_level_reg;

    // Configuration
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                clm_pkg::REG_BAR_FALLOFF:  cfg_next.bar_falloff      = cfg_data;
                clm_pkg::REG_PEAK_FALLOFF: cfg_next.peak_falloff     = cfg_data;
                clm_pkg::REG_PEAK_HOLD:
                    cfg_next.peak_hold_frames = cfg_data[clm_pkg::HOLD_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bar_falloff      <= clm_pkg::BAR_FALLOFF_RST;
            cfg_reg.peak_falloff     <= clm_pkg::PEAK_FALLOFF_RST;
            cfg_reg.peak_hold_frames <= clm_pkg::PEAK_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshake and pipeline control
    assign advance    = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign s1_valid_next     = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign result_valid_next = advance ? 1'b1 : (result_valid_reg && result_stall);

    assign rd_addr  = clm_pkg::ADDR_W'(channel);
    assign in_range = (32'(channel) < clm_pkg::CHANNELS);
    assign s1_addr  = clm_pkg::ADDR_W'(s1_ch_reg);
    assign wr_en    = advance && s1_inrange_reg;

    always_comb
    begin
        seen_next = seen_reg;
        if (wr_en)
        begin
            seen_next[s1_addr] = 1'b1;
        end
    end

    // State RAM
    clm_ram #(
        .WIDTH(clm_pkg::ENTRY_W),
        .DEPTH(clm_pkg::CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (upd),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Pick bypass, RAM data, or the cleared value for a never-written channel.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            cur = fwd_data_reg;
        end
        else if (s1_seen_reg)
        begin
            cur = clm_pkg::entry_t'(rd_data);
        end
        else
        begin
            cur = '0;
        end
    end

    clm_update u_update (
        .cfg      (cfg_reg),
        .cur      (cur),
        .velocity (s1_vel_reg),
        .upd      (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            seen_reg         <= '0;
            fwd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            seen_reg         <= seen_next;
            result_valid_reg <= result_valid_next;
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg      <= channel;
            s1_vel_reg     <= velocity;
            s1_seen_reg    <= seen_reg[rd_addr];
            s1_inrange_reg <= in_range;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= upd;
        end
        if (advance)
        begin
            channel_out_reg <= s1_ch_reg;
            bar_level_reg   <= s1_inrange_reg ? upd.bar  : '0;
            peak_level_reg  <= s1_inrange_reg ? upd.peak : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign channel_out  = channel_out_reg;
    assign bar_level    = bar_level_reg;
    assign peak_level   = peak_level_reg;

    // Checks
    `CLM_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg, "accepted beat lost")
    `CLM_ASSERT_IMP(a_write_on_advance, wr_en, advance && s1_valid_reg, "write without advance")
    `CLM_ASSERT_NEXT(a_s1_holds, item_stall, s1_valid_reg && $stable(s1_ch_reg), "stage moved")

endmodule

// File: tb/channel_level_meter_peak_hold_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the per-channel bar meter with peak hold.
module channel_level_meter_peak_hold_tb;
    import clm_pkg::*;

    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [LEVEL_W-1:0]   LEVEL_TOP = 15'd32512;

    typedef struct {
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] bar;
        logic [LEVEL_W-1:0] peak;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid;
    logic                 item_stall;
    logic [CH_W-1:0]      channel;
    logic [VEL_W-1:0]     velocity;
    logic                 result_valid;
    logic                 result_stall;
    logic [CH_W-1:0]      channel_out;
    logic [LEVEL_W-1:0]   bar_level;
    logic [LEVEL_W-1:0]   peak_level;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_data;

    reading_t           pending_readings[$];
    logic [LEVEL_W-1:0] bar_track [CHANNELS];
    logic [LEVEL_W-1:0] peak_track [CHANNELS];
    logic [HOLD_W-1:0]  hold_left [CHANNELS];
    logic [LEVEL_W-1:0] bar_decay;
    logic [LEVEL_W-1:0] peak_decay;
    logic [HOLD_W-1:0]  hold_reload;

    int error_count = 0;
    bit sender_steady = 1'b0;
    bit receiver_steady = 1'b0;
    int receiver_hold_off = 0;

    channel_level_meter_peak_hold uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .channel      (channel),
        .velocity     (velocity),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .channel_out  (channel_out),
        .bar_level    (bar_level),
        .peak_level   (peak_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void reset_meter_model();
        bar_decay   = BAR_FALLOFF_RST;
        peak_decay  = PEAK_FALLOFF_RST;
        hold_reload = PEAK_HOLD_RST;
        for (int i = 0; i < CHANNELS; i++)
        begin
            bar_track[i]  = '0;
            peak_track[i] = '0;
            hold_left[i]  = '0;
        end
    endfunction

    // One frame of the meter: bar jumps up or falls, peak captures or decays after hold.
    function automatic reading_t advance_meter(input logic [CH_W-1:0] ch,
                                               input logic [VEL_W-1:0] vel);
        reading_t           r;
        logic [LEVEL_W-1:0] lvl;
        logic [LEVEL_W-1:0] bar;
        logic [LEVEL_W-1:0] peak;
        logic [HOLD_W-1:0]  hold;
        r.ch   = ch;
        r.bar  = '0;
        r.peak = '0;
        lvl = {vel, {FRAC_W{1'b0}}};
        if (int'(ch) < CHANNELS)
        begin
            bar  = bar_track[ch];
            peak = peak_track[ch];
            hold = hold_left[ch];
            if (lvl >= bar)
                bar = lvl;
            else
                bar = (bar > bar_decay) ? bar - bar_decay : '0;
            if (bar >= peak)
            begin
                peak = bar;
                hold = hold_reload;
            end
            if (hold == '0 && peak != '0)
                peak = (peak > peak_decay) ? peak - peak_decay : '0;
            else if (hold != '0)
                hold = hold - 1'b1;
            bar_track[ch]  = bar;
            peak_track[ch] = peak;
            hold_left[ch]  = hold;
            r.bar  = bar;
            r.peak = peak;
        end
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_falloff();
        if ($urandom_range(0, 3) == 0)
            return LEVEL_W'($urandom_range(0, 32512));
        return LEVEL_W'($urandom_range(0, 2047));
    endfunction

    function automatic logic [HOLD_W-1:0] pick_hold();
        if ($urandom_range(0, 3) == 0)
            return HOLD_W'($urandom_range(0, 255));
        return HOLD_W'($urandom_range(0, 6));
    endfunction

    function automatic logic [VEL_W-1:0] pick_velocity();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return VEL_W'($urandom_range(0, 127));
            2:       return VEL_W'($urandom_range(100, 127));
            default: return VEL_W'($urandom_range(0, 24));
        endcase
    endfunction

    // Offer one frame; valid stays high across back-to-back beats.
    task automatic send_frame(input logic [CH_W-1:0] ch, input logic [VEL_W-1:0] vel);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        channel    <= ch;
        velocity   <= vel;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_readings.push_back(advance_meter(ch, vel));
    endtask

    // Drop valid and hold until every reading is back.
    task automatic drain_readings();
        item_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_BAR_FALLOFF:  bar_decay   = data;
            REG_PEAK_FALLOFF: peak_decay  = data;
            REG_PEAK_HOLD:    hold_reload = data[HOLD_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic load_settings(input logic [LEVEL_W-1:0] bar_fall,
                                 input logic [LEVEL_W-1:0] peak_fall,
                                 input logic [HOLD_W-1:0]  hold_frames);
        logic [LEVEL_W-HOLD_W-1:0] upper;
        upper = (LEVEL_W-HOLD_W)'($urandom);
        drain_readings();
        write_reg(REG_BAR_FALLOFF, bar_fall);
        write_reg(REG_PEAK_FALLOFF, peak_fall);
        // upper data bits are don't-care for the hold register
        write_reg(REG_PEAK_HOLD, {upper, hold_frames});
        write_reg(REG_SPARE, LEVEL_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        sender_steady = 1'b1;
        send_frame(4'd0, 7'd127);
        send_frame(4'd0, 7'd0);
        send_frame(4'd0, 7'd0);
        send_frame(4'd0, 7'd5);
        send_frame(4'd15, 7'd0);
        send_frame(4'd15, 7'd0);
        send_frame(4'd7, 7'd64);
        send_frame(4'd7, 7'd65);
        send_frame(4'd7, 7'd1);
        sender_steady = 1'b0;
        send_frame(4'd0, 7'd0);
        send_frame(4'd7, 7'd0);
    endtask

    task automatic test_hold_settings();
        // zero hold: peak decays in the capture frame; zero falloff leaves the bar up
        load_settings('0, '0, '0);
        send_frame(4'd3, 7'd100);
        send_frame(4'd3, 7'd100);
        send_frame(4'd3, 7'd0);
        send_frame(4'd9, 7'd0);
        load_settings(LEVEL_TOP, LEVEL_TOP, 8'd1);
        send_frame(4'd4, 7'd127);
        send_frame(4'd4, 7'd0);
        send_frame(4'd4, 7'd0);
        send_frame(4'd4, 7'd126);
        send_frame(4'd4, 7'd0);
        load_settings(15'd1, 15'd3, 8'hFF);
        send_frame(4'd5, 7'd127);
        send_frame(4'd5, 7'd126);
        send_frame(4'd5, 7'd0);
    endtask

    task automatic test_random_frames();
        int span;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       load_settings('0, '0, '0);
                1:       load_settings(LEVEL_TOP, LEVEL_TOP, 8'hFF);
                default: load_settings(pick_falloff(), pick_falloff(), pick_hold());
            endcase
            // few channels keep the hold counters running out
            case ($urandom_range(0, 3))
                0:       span = 0;
                1:       span = 1;
                2:       span = 3;
                default: span = 15;
            endcase
            for (int n = 0; n < 300; n++)
            begin
                if (n % 40 == 0)
                begin
                    sender_steady   = ($urandom_range(0, 3) == 0);
                    receiver_steady = ($urandom_range(0, 3) == 0);
                end
                send_frame(CH_W'($urandom_range(0, span)), pick_velocity());
            end
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        load_settings(pick_falloff(), pick_falloff(), pick_hold());
        sender_steady = 1'b1;
        // sink holds off after the next beat while frames keep coming
        receiver_hold_off = 60;
        for (int n = 0; n < 40; n++)
            send_frame(CH_W'($urandom_range(0, 15)), pick_velocity());
        sender_steady = 1'b0;
    endtask

    task automatic test_sender_pause();
        for (int burst = 0; burst < 4; burst++)
        begin
            for (int n = 0; n < 10; n++)
                send_frame(CH_W'($urandom_range(0, 1)), pick_velocity());
            drain_readings();
        end
    endtask

    initial
    begin : result_sink
        int wait_cycles;
        result_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (receiver_hold_off > 0)
            begin
                wait_cycles = receiver_hold_off;
                receiver_hold_off = 0;
            end
            else
                wait_cycles = receiver_steady ? 0 : $urandom_range(0, 9);
            if (wait_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("result beat with no reading pending: channel_out %0d", channel_out);
                error_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (channel_out !== want.ch)
                begin
                    $error("channel_out: expected %0d, got %0d", want.ch, channel_out);
                    error_count++;
                end
                if (bar_level !== want.bar)
                begin
                    $error("bar_level: expected %0d, got %0d", want.bar, bar_level);
                    error_count++;
                end
                if (peak_level !== want.peak)
                begin
                    $error("peak_level: expected %0d, got %0d", want.peak, peak_level);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("channel_level_meter_peak_hold regression: fail");
        $finish;
    end

    initial
    begin
        item_valid <= 1'b0;
        channel    <= '0;
        velocity   <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_BAR_FALLOFF;
        cfg_data   <= '0;
        reset_meter_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_hold_settings();
        test_random_frames();
        test_backpressure();
        test_sender_pause();

        drain_readings();
        repeat (4) @(posedge clk);
        if (error_count == 0 && pending_readings.size() == 0)
            $display("channel_level_meter_peak_hold regression: pass");
        else
            $display("channel_level_meter_peak_hold regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/clm_pkg.sv
design/clm_ram.sv
design/clm_update.sv
design/channel_level_meter_peak_hold.sv
tb/channel_level_meter_peak_hold_tb.sv
